// ===== design/gsm_pkg.sv =====
package gsm_pkg;

	// sizing
	localparam int MAX_GROUP  = 256;
	localparam int MAX_DIM    = 4096;
	localparam int LANE       = 8;
	localparam int GPR_MAX    = 512;

	localparam int GS_W       = $clog2(MAX_GROUP) + 1;
	localparam int GPR_W      = $clog2(GPR_MAX) + 1;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int DIMC_W     = DIM_W + 1;

	// datapath widths
	localparam int ELEM_W     = 8;
	localparam int EPROD_W    = 2 * ELEM_W;
	localparam int SCALE_W    = 24;
	localparam int SUM_W      = 24;
	localparam int PROD_W     = 2 * SCALE_W;
	localparam int FRAC_W     = 16;
	localparam int SC_W       = PROD_W - FRAC_W;
	localparam int TERM_W     = SC_W + SUM_W;
	localparam int ACC_W      = 64;

	// config port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GROUP_SIZE     = 4'd0,
		REG_GROUPS_PER_ROW = 4'd1,
		REG_ACT_ROWS       = 4'd2,
		REG_WT_ROWS        = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GS_W-1:0]   group_size;
		logic [GPR_W-1:0]  groups_per_row;
		logic [DIMC_W-1:0] act_rows;
		logic [DIMC_W-1:0] wt_rows;
	} cfg_t;

	// output bookkeeping carried with each group term
	typedef struct packed {
		logic             row_end;
		logic             last;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
	} out_meta_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]   gsum;
		logic signed [SCALE_W-1:0] act_scale;
		logic signed [SCALE_W-1:0] wt_scale;
		out_meta_t                 meta;
	} grp_entry_t;

endpackage

// ===== design/gsm_if.sv =====
interface gsm_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [gsm_pkg::ELEM_W-1:0]       act_elem;
	logic signed [gsm_pkg::ELEM_W-1:0]       wt_elem;
	logic signed [gsm_pkg::SCALE_W-1:0]      act_scale;
	logic signed [gsm_pkg::SCALE_W-1:0]      wt_scale;

	modport source (output valid, act_elem, wt_elem, act_scale, wt_scale, input ready);
	modport sink   (input valid, act_elem, wt_elem, act_scale, wt_scale, output ready);
endinterface

interface gsm_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [gsm_pkg::ACC_W-1:0]        dot_value;
	logic [gsm_pkg::DIM_W-1:0]               out_row;
	logic [gsm_pkg::DIM_W-1:0]               out_col;
	logic                                    last_output;

	modport source (output valid, dot_value, out_row, out_col, last_output, input ready);
	modport sink   (input valid, dot_value, out_row, out_col, last_output, output ready);
endinterface

interface gsm_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [gsm_pkg::CFG_IDX_W-1:0]           index;
	logic [gsm_pkg::CFG_DATA_W-1:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/gsm_fifo.sv =====
module gsm_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gsm_pkg::grp_entry_t wr_data,
	input  logic                pop,
	output gsm_pkg::grp_entry_t rd_data,
	output logic                full,
	output logic                empty
);

	gsm_pkg::grp_entry_t              mem_q [gsm_pkg::FIFO_DEPTH];
	logic [gsm_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [gsm_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [gsm_pkg::FIFO_CW-1:0]      count_q;

	assign full    = (count_q == gsm_pkg::FIFO_CW'(gsm_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("group queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("group queue read while empty");
`endif

endmodule

// ===== design/gsm_front.sv =====
module gsm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  gsm_pkg::cfg_t       cfg,
	gsm_in_if.sink              item,
	input  logic                q_full,
	output logic                q_push,
	output gsm_pkg::grp_entry_t q_data
);

	logic signed [gsm_pkg::SUM_W-1:0]   sum_q;
	logic [gsm_pkg::GS_W-1:0]           elem_q;
	logic [gsm_pkg::GPR_W-1:0]          grp_q;
	logic [gsm_pkg::DIM_W-1:0]          row_q;
	logic [gsm_pkg::DIM_W-1:0]          col_q;

	logic                               accept;
	logic signed [gsm_pkg::EPROD_W-1:0] eprod;
	logic signed [gsm_pkg::SUM_W-1:0]   sum_nx;
	logic [gsm_pkg::GS_W-1:0]           elem_nx;
	logic [gsm_pkg::GPR_W-1:0]          grp_nx;
	logic [gsm_pkg::DIMC_W-1:0]         row_nx;
	logic [gsm_pkg::DIMC_W-1:0]         col_nx;
	logic                               grp_end;
	logic                               row_end;
	logic                               col_wrap;
	logic                               row_wrap;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;

	// element MAC and group/output position
	always_comb begin
		eprod    = item.act_elem * item.wt_elem;
		sum_nx   = sum_q + {{(gsm_pkg::SUM_W - gsm_pkg::EPROD_W){eprod[gsm_pkg::EPROD_W-1]}},
			eprod};
		elem_nx  = elem_q + 1'b1;
		grp_nx   = grp_q + 1'b1;
		col_nx   = {1'b0, col_q} + 1'b1;
		row_nx   = {1'b0, row_q} + 1'b1;
		grp_end  = (elem_nx >= cfg.group_size);
		row_end  = (grp_nx >= cfg.groups_per_row);
		col_wrap = (col_nx >= cfg.wt_rows);
		row_wrap = (row_nx >= cfg.act_rows);
	end

	// group entry handed to the back end
	assign q_push              = accept && grp_end;
	assign q_data.gsum         = sum_nx;
	assign q_data.act_scale    = item.act_scale;
	assign q_data.wt_scale     = item.wt_scale;
	assign q_data.meta.row_end = row_end;
	assign q_data.meta.last    = col_wrap && row_wrap;
	assign q_data.meta.row     = row_q;
	assign q_data.meta.col     = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			elem_q <= '0;
			grp_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (!grp_end) begin
				sum_q  <= sum_nx;
				elem_q <= elem_nx;
			end else begin
				sum_q  <= '0;
				elem_q <= '0;
				if (!row_end) begin
					grp_q <= grp_nx;
				end else begin
					grp_q <= '0;
					if (!col_wrap) begin
						col_q <= col_nx[gsm_pkg::DIM_W-1:0];
					end else begin
						col_q <= '0;
						row_q <= row_wrap ? '0 : row_nx[gsm_pkg::DIM_W-1:0];
					end
				end
			end
		end
	end

endmodule

// ===== design/gsm_back.sv =====
module gsm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gsm_pkg::grp_entry_t q_data,
	input  logic                q_empty,
	output logic                q_pop,
	gsm_out_if.source           result
);

	localparam logic signed [gsm_pkg::PROD_W-1:0] RND_HALF =
		gsm_pkg::PROD_W'(1) <<< (gsm_pkg::FRAC_W - 1);
	localparam logic signed [gsm_pkg::ACC_W-1:0] ACC_MAX =
		{1'b0, {(gsm_pkg::ACC_W-1){1'b1}}};
	localparam logic signed [gsm_pkg::ACC_W-1:0] ACC_MIN =
		{1'b1, {(gsm_pkg::ACC_W-1){1'b0}}};

	// pipeline stages
	logic                                 v_s1, v_s2, v_s3;
	logic signed [gsm_pkg::PROD_W-1:0]    prod_s1;
	logic signed [gsm_pkg::SC_W-1:0]      sc_s2;
	logic signed [gsm_pkg::TERM_W-1:0]    term_s3;
	logic signed [gsm_pkg::SUM_W-1:0]     gsum_s1, gsum_s2;
	gsm_pkg::out_meta_t                   meta_s1, meta_s2, meta_s3;

	logic signed [gsm_pkg::ACC_W-1:0]     acc_q;
	logic                                 out_v_q;
	logic signed [gsm_pkg::ACC_W-1:0]     out_val_q;
	gsm_pkg::out_meta_t                   out_meta_q;

	logic                                 en;
	logic                                 emit;
	logic signed [gsm_pkg::PROD_W-1:0]    rnd;
	logic [gsm_pkg::ACC_W:0]              acc_wide;
	logic signed [gsm_pkg::ACC_W-1:0]     acc_sat;

	// hold the pipe only when a finished row meets an occupied output register that the receiver is not taking
	assign en    = !(v_s3 && meta_s3.row_end && out_v_q && !result.ready);
	assign emit  = en && v_s3 && meta_s3.row_end;
	assign q_pop = en && !q_empty;

	// scale rounding, half toward plus infinity
	assign rnd = prod_s1 + RND_HALF;

	// saturating accumulate
	always_comb begin
		acc_wide = {acc_q[gsm_pkg::ACC_W-1], acc_q}
			+ {{(gsm_pkg::ACC_W + 1 - gsm_pkg::TERM_W){term_s3[gsm_pkg::TERM_W-1]}}, term_s3};
		priority if (acc_wide[gsm_pkg::ACC_W] != acc_wide[gsm_pkg::ACC_W-1]) begin
			acc_sat = acc_wide[gsm_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_wide[gsm_pkg::ACC_W-1:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			acc_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= !q_empty;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (v_s3) acc_q <= meta_s3.row_end ? '0 : acc_sat;
			end
			if (emit)              out_v_q <= 1'b1;
			else if (result.ready) out_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= q_data.act_scale * q_data.wt_scale;
			gsum_s1 <= q_data.gsum;
			meta_s1 <= q_data.meta;
			sc_s2   <= rnd[gsm_pkg::PROD_W-1:gsm_pkg::FRAC_W];
			gsum_s2 <= gsum_s1;
			meta_s2 <= meta_s1;
			term_s3 <= sc_s2 * gsum_s2;
			meta_s3 <= meta_s2;
		end
		if (emit) begin
			out_val_q  <= acc_sat;
			out_meta_q <= meta_s3;
		end
	end

	assign result.valid       = out_v_q;
	assign result.dot_value   = out_val_q;
	assign result.out_row     = out_meta_q.row;
	assign result.out_col     = out_meta_q.col;
	assign result.last_output = out_meta_q.last;

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (out_v_q && v_s3 && meta_s3.row_end))
		else $error("pipe held without a waiting result");
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (acc_q == '0 && out_v_q))
		else $error("accumulator not cleared after a row result");
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && result.ready && !emit) |=> !out_v_q)
		else $error("taken result still shown");
`endif

endmodule

// ===== design/group_scaled_int8_matmul_top.sv =====
// Group-scaled int8 matrix product.
// item:   one beat per element pair (act_elem, wt_elem). act_scale and wt_scale
//         are sampled only on the last element of each group.
// result: one beat per output (dot_value, out_row, out_col, last_output), in
//         row-major order, column fastest; last_output marks the final output.
// cfg:    register writes (0 group_size, 1 groups_per_row, 2 act_rows,
//         3 wt_rows), always ready; write only while no beat is in flight.
// Throughput: one item per cycle while the queue is not full. The front MAC folds one
// pair per cycle; each group end queues one entry, and the back end (scale multiply,
// round, term multiply, saturating add) takes one entry per cycle unless its pipe is held.
// A result's last group entry passes the queue, stages s1, s2, s3 and the output register.
// Reset: clears all counters, the accumulator, the queue and the result
// register; registers return to 32, 1, 1, 1.
// A stalled result receiver holds the back pipe only when another output
// is ready to leave; the 4-entry queue then fills and item.ready drops.
module group_scaled_int8_matmul_top (
	input  logic      clk,
	input  logic      arst_n,
	gsm_in_if.sink    item,
	gsm_out_if.source result,
	gsm_cfg_if.sink   cfg
);

	gsm_pkg::cfg_t       cfg_q;
	gsm_pkg::grp_entry_t push_data;
	gsm_pkg::grp_entry_t pop_data;
	logic                push, pop, q_full, q_empty;

	logic [gsm_pkg::GS_W-1:0]   gs_raw;
	logic [gsm_pkg::GPR_W-1:0]  gpr_raw;
	logic [gsm_pkg::DIMC_W-1:0] dim_raw;
	logic [gsm_pkg::GS_W-1:0]   gs_clamp;
	logic [gsm_pkg::GPR_W-1:0]  gpr_clamp;
	logic [gsm_pkg::DIMC_W-1:0] dim_clamp;

	assign cfg.ready = 1'b1;

	// register write clamping
	always_comb begin
		gs_raw  = {cfg.data[gsm_pkg::GS_W-1:3], 3'b000};
		gpr_raw = cfg.data[gsm_pkg::GPR_W-1:0];
		dim_raw = cfg.data[gsm_pkg::DIMC_W-1:0];
		priority if (gs_raw < gsm_pkg::GS_W'(gsm_pkg::LANE))
			gs_clamp = gsm_pkg::GS_W'(gsm_pkg::LANE);
		else if (gs_raw > gsm_pkg::GS_W'(gsm_pkg::MAX_GROUP))
			gs_clamp = gsm_pkg::GS_W'(gsm_pkg::MAX_GROUP);
		else
			gs_clamp = gs_raw;
		priority if (gpr_raw == '0)
			gpr_clamp = gsm_pkg::GPR_W'(1);
		else if (gpr_raw > gsm_pkg::GPR_W'(gsm_pkg::GPR_MAX))
			gpr_clamp = gsm_pkg::GPR_W'(gsm_pkg::GPR_MAX);
		else
			gpr_clamp = gpr_raw;
		priority if (dim_raw == '0)
			dim_clamp = gsm_pkg::DIMC_W'(1);
		else if (dim_raw > gsm_pkg::DIMC_W'(gsm_pkg::MAX_DIM))
			dim_clamp = gsm_pkg::DIMC_W'(gsm_pkg::MAX_DIM);
		else
			dim_clamp = dim_raw;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_size     <= gsm_pkg::GS_W'(32);
			cfg_q.groups_per_row <= gsm_pkg::GPR_W'(1);
			cfg_q.act_rows       <= gsm_pkg::DIMC_W'(1);
			cfg_q.wt_rows        <= gsm_pkg::DIMC_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gsm_pkg::REG_GROUP_SIZE:     cfg_q.group_size     <= gs_clamp;
				gsm_pkg::REG_GROUPS_PER_ROW: cfg_q.groups_per_row <= gpr_clamp;
				gsm_pkg::REG_ACT_ROWS:       cfg_q.act_rows       <= dim_clamp;
				gsm_pkg::REG_WT_ROWS:        cfg_q.wt_rows        <= dim_clamp;
				default: ;
			endcase
		end
	end

	gsm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.q_full (q_full),
		.q_push (push),
		.q_data (push_data)
	);

	gsm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (pop_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	gsm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (pop_data),
		.q_empty (q_empty),
		.q_pop   (pop),
		.result  (result)
	);

endmodule

// ===== sim/group_scaled_int8_matmul_top_test.sv =====
`timescale 1ns / 1ps

module group_scaled_int8_matmul_top_test;

	localparam int RESULT_LATENCY = 4;
	localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
	localparam longint RUN_LIMIT_NS = 64'd20_000_000;

	// power-on register values
	localparam int unsigned RST_GROUP_SIZE = 32;
	localparam int unsigned RST_GPR        = 1;
	localparam int unsigned RST_DIM        = 1;

	// no register lives at this index
	localparam logic [gsm_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = '1;

	localparam logic signed [gsm_pkg::ELEM_W-1:0] ELEM_MIN =
		{1'b1, {(gsm_pkg::ELEM_W-1){1'b0}}};
	localparam logic signed [gsm_pkg::ELEM_W-1:0] ELEM_MAX = ~ELEM_MIN;
	localparam logic signed [gsm_pkg::SCALE_W-1:0] SCALE_MIN =
		{1'b1, {(gsm_pkg::SCALE_W-1){1'b0}}};
	localparam logic signed [gsm_pkg::SCALE_W-1:0] SCALE_MAX = ~SCALE_MIN;
	localparam logic signed [gsm_pkg::SCALE_W-1:0] HALF_LSB =
		gsm_pkg::SCALE_W'(1 << (gsm_pkg::FRAC_W - 1));

	typedef struct packed {
		logic signed [gsm_pkg::ACC_W-1:0] dot_value;
		logic [gsm_pkg::DIM_W-1:0]        row;
		logic [gsm_pkg::DIM_W-1:0]        col;
		logic                             last;
	} dot_result_t;

	typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

	logic clk;
	logic arst_n;

	gsm_in_if  in_ch ();
	gsm_out_if out_ch ();
	gsm_cfg_if cfg_ch ();

	group_scaled_int8_matmul_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the block's registers and running state
	int unsigned                      gs_lim, gpr_lim, act_lim, wt_lim;
	int                               grp_sum;
	int unsigned                      elem_cnt, grp_cnt, row_idx, col_idx;
	logic signed [gsm_pkg::ACC_W-1:0] dot_acc;

	dot_result_t expected_dots[$];
	dot_result_t head;
	int unsigned outputs_predicted;
	int unsigned mismatch_count;

	int       burst_left;
	rx_mode_t rx_mode;
	int       rx_phase_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void reset_predictor();
		gs_lim = RST_GROUP_SIZE;
		gpr_lim = RST_GPR;
		act_lim = RST_DIM;
		wt_lim = RST_DIM;
		grp_sum = 0;
		elem_cnt = 0;
		grp_cnt = 0;
		row_idx = 0;
		col_idx = 0;
		dot_acc = '0;
	endfunction

	// register write: mask to width, round group size down to a lane, clamp
	function automatic void apply_reg(logic [gsm_pkg::CFG_IDX_W-1:0] idx,
			logic [gsm_pkg::CFG_DATA_W-1:0] data);
		unique case (idx)
			gsm_pkg::REG_GROUP_SIZE: begin
				gs_lim = clamp_to(32'(data[gsm_pkg::GS_W-1:0]) / gsm_pkg::LANE * gsm_pkg::LANE,
					gsm_pkg::LANE, gsm_pkg::MAX_GROUP);
			end
			gsm_pkg::REG_GROUPS_PER_ROW: begin
				gpr_lim = clamp_to(32'(data[gsm_pkg::GPR_W-1:0]), 1, gsm_pkg::GPR_MAX);
			end
			gsm_pkg::REG_ACT_ROWS: begin
				act_lim = clamp_to(32'(data[gsm_pkg::DIMC_W-1:0]), 1, gsm_pkg::MAX_DIM);
			end
			gsm_pkg::REG_WT_ROWS: begin
				wt_lim = clamp_to(32'(data[gsm_pkg::DIMC_W-1:0]), 1, gsm_pkg::MAX_DIM);
			end
			default: ;
		endcase
	endfunction

	// one accepted pair: MAC, group-end scaling, output emission
	function automatic void accept_pair(logic signed [gsm_pkg::ELEM_W-1:0] a,
			logic signed [gsm_pkg::ELEM_W-1:0] w,
			logic signed [gsm_pkg::SCALE_W-1:0] sa, logic signed [gsm_pkg::SCALE_W-1:0] sw);
		longint                         scale_prod;
		longint                         scale_q16;
		longint                         term;
		logic signed [gsm_pkg::ACC_W:0] wide;
		dot_result_t                    r;

		grp_sum += int'(a) * int'(w);
		elem_cnt++;
		if (elem_cnt < gs_lim)
			return;

		// round half toward plus infinity
		scale_prod = longint'(sa) * longint'(sw);
		scale_q16 = (scale_prod + 32768) >>> gsm_pkg::FRAC_W;
		term = scale_q16 * longint'(grp_sum);
		wide = dot_acc + term;
		if (wide[gsm_pkg::ACC_W] != wide[gsm_pkg::ACC_W-1])
			dot_acc = wide[gsm_pkg::ACC_W] ? {1'b1, {(gsm_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(gsm_pkg::ACC_W-1){1'b1}}};
		else
			dot_acc = wide[gsm_pkg::ACC_W-1:0];
		grp_sum = 0;
		elem_cnt = 0;
		grp_cnt++;
		if (grp_cnt < gpr_lim)
			return;

		r.dot_value = dot_acc;
		r.row = row_idx[gsm_pkg::DIM_W-1:0];
		r.col = col_idx[gsm_pkg::DIM_W-1:0];
		r.last = (row_idx + 1 >= act_lim) && (col_idx + 1 >= wt_lim);
		expected_dots.push_back(r);
		outputs_predicted++;

		dot_acc = '0;
		grp_cnt = 0;
		col_idx++;
		if (col_idx >= wt_lim) begin
			col_idx = 0;
			row_idx++;
			if (row_idx >= act_lim)
				row_idx = 0;
		end
	endfunction

	function automatic logic signed [gsm_pkg::ELEM_W-1:0] rand_elem();
		unique case ($urandom_range(0, 7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return '0;
			default: return gsm_pkg::ELEM_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [gsm_pkg::SCALE_W-1:0] rand_scale();
		unique case ($urandom_range(0, 7))
			0: return SCALE_MIN;
			1: return SCALE_MAX;
			2: return gsm_pkg::SCALE_W'($signed($urandom_range(0, 131071)) - 65536);
			default: return gsm_pkg::SCALE_W'($urandom);
		endcase
	endfunction

	// random bits above a register's width, which the block must ignore
	function automatic logic [gsm_pkg::CFG_DATA_W-1:0] above(int w);
		return gsm_pkg::CFG_DATA_W'($urandom) << w;
	endfunction

	// pair beat, sent in bursts with random gaps; call at a falling edge
	task automatic send_pair(input logic signed [gsm_pkg::ELEM_W-1:0] a,
			input logic signed [gsm_pkg::ELEM_W-1:0] w,
			input logic signed [gsm_pkg::SCALE_W-1:0] sa,
			input logic signed [gsm_pkg::SCALE_W-1:0] sw);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
				: $urandom_range(1, 16);
			if (gap > 0) begin
				if (in_ch.valid)
					in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.act_elem <= a;
		in_ch.wt_elem <= w;
		in_ch.act_scale <= sa;
		in_ch.wt_scale <= sw;
		do @(posedge clk); while (!in_ch.ready);
		accept_pair(a, w, sa, sw);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_random_pair();
		send_pair(rand_elem(), rand_elem(), rand_scale(), rand_scale());
	endtask

	// fixed elements; scales matter only on the closing beat
	task automatic send_group(input logic signed [gsm_pkg::ELEM_W-1:0] a,
			input logic signed [gsm_pkg::ELEM_W-1:0] w,
			input logic signed [gsm_pkg::SCALE_W-1:0] sa,
			input logic signed [gsm_pkg::SCALE_W-1:0] sw,
			input int len);
		for (int i = 0; i < len - 1; i++)
			send_pair(a, w, rand_scale(), rand_scale());
		send_pair(a, w, sa, sw);
	endtask

	// run out the current output so the next one starts clean
	task automatic finish_output();
		while (elem_cnt != 0 || grp_cnt != 0)
			send_random_pair();
	endtask

	// stop the stream, collect every result, let the back pipe empty
	task automatic settle_block();
		if (in_ch.valid)
			in_ch.valid <= 1'b0;
		while (expected_dots.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [gsm_pkg::CFG_IDX_W-1:0] idx,
			input logic [gsm_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned gs, input int unsigned gpr,
			input int unsigned act, input int unsigned wt);
		settle_block();
		write_reg(gsm_pkg::REG_GROUP_SIZE,
			gsm_pkg::CFG_DATA_W'(gs) | above(gsm_pkg::GS_W)
			| gsm_pkg::CFG_DATA_W'($urandom_range(0, gsm_pkg::LANE - 1)));
		write_reg(gsm_pkg::REG_GROUPS_PER_ROW,
			gsm_pkg::CFG_DATA_W'(gpr) | above(gsm_pkg::GPR_W));
		write_reg(gsm_pkg::REG_ACT_ROWS, gsm_pkg::CFG_DATA_W'(act) | above(gsm_pkg::DIMC_W));
		write_reg(gsm_pkg::REG_WT_ROWS, gsm_pkg::CFG_DATA_W'(wt) | above(gsm_pkg::DIMC_W));
	endtask

	// clamps at both ends, dropped high bits, unmapped index, rounding
	task automatic test_register_limits();
		write_reg(gsm_pkg::REG_GROUP_SIZE, 16'hFFFF);
		write_reg(gsm_pkg::REG_GROUPS_PER_ROW, 16'hFFFF);
		write_reg(gsm_pkg::REG_GROUP_SIZE, 16'h0007);
		write_reg(gsm_pkg::REG_GROUPS_PER_ROW, 16'hFC00);
		write_reg(gsm_pkg::REG_ACT_ROWS, 16'hE000);
		write_reg(gsm_pkg::REG_WT_ROWS, 16'hFFFF);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		// largest positive group term
		send_group(ELEM_MIN, ELEM_MIN, SCALE_MIN, SCALE_MIN, gsm_pkg::LANE);
		// scale product of -1.5 LSB rounds to -1
		send_group(ELEM_MAX, ELEM_MIN, gsm_pkg::SCALE_W'(-3), HALF_LSB, gsm_pkg::LANE);
		// scale product of +1.5 LSB rounds to +2
		send_group(ELEM_MAX, ELEM_MAX, gsm_pkg::SCALE_W'(3), HALF_LSB, gsm_pkg::LANE);
	endtask

	// shrink limits while counters sit above them
	task automatic test_partial_reconfig();
		configure(2 * gsm_pkg::LANE, 3, 3, 3);
		repeat (2 * 3 * 2 * gsm_pkg::LANE + 2 * 2 * gsm_pkg::LANE + 12)
			send_random_pair();
		configure(gsm_pkg::LANE, 2, 1, 2);
		repeat (40)
			send_random_pair();
		finish_output();
	endtask

	// widest group at the largest term, then a negative scale product
	task automatic test_largest_terms();
		configure(gsm_pkg::LANE, 1, 1, 1);
		write_reg(gsm_pkg::REG_GROUP_SIZE, 16'hFFFF);
		send_group(ELEM_MIN, ELEM_MIN, SCALE_MIN, SCALE_MIN, gsm_pkg::MAX_GROUP);
		configure(gsm_pkg::LANE, 1, 1, 1);
		send_group(ELEM_MIN, ELEM_MIN, SCALE_MAX, SCALE_MIN, gsm_pkg::LANE);
	endtask

	// many groups folded into one output
	task automatic test_longest_row();
		configure(gsm_pkg::LANE, 8, 2, 1);
		repeat (gsm_pkg::LANE * 8)
			send_random_pair();
	endtask

	task automatic test_random_mix();
		int unsigned sent;
		int unsigned first_output;
		sent = 0;
		first_output = outputs_predicted;
		while (sent < 60 || outputs_predicted - first_output < 4) begin
			configure(($urandom_range(0, 2) == 0) ? gsm_pkg::LANE * $urandom_range(2, 6)
				: gsm_pkg::LANE,
				$urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(1, 4));
			repeat (30)
				send_random_pair();
			sent += 30;
		end
		finish_output();
	endtask

	// walk the whole matrix once and into the next
	task automatic test_index_wrap(input int unsigned rows, input int unsigned cols);
		configure(gsm_pkg::LANE, 1, rows, cols);
		repeat ((rows * cols + 1) * gsm_pkg::LANE)
			send_random_pair();
	endtask

	// receiver back-pressure pattern
	always @(negedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_phase_left = $urandom_range(16, 256);
		end
		rx_phase_left--;
		unique case (rx_mode)
			RX_OPEN:   out_ch.ready <= 1'b1;
			RX_CHOPPY: out_ch.ready <= ($urandom_range(0, 1) == 1);
			default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_dots.size() == 0) begin
				$error("unexpected result beat: row %0d col %0d", out_ch.out_row, out_ch.out_col);
				mismatch_count++;
			end else begin
				head = expected_dots.pop_front();
				if (out_ch.dot_value !== head.dot_value) begin
					$error("dot_value: expected %0d, got %0d", head.dot_value, out_ch.dot_value);
					mismatch_count++;
				end
				if (out_ch.out_row !== head.row) begin
					$error("out_row: expected %0d, got %0d", head.row, out_ch.out_row);
					mismatch_count++;
				end
				if (out_ch.out_col !== head.col) begin
					$error("out_col: expected %0d, got %0d", head.col, out_ch.out_col);
					mismatch_count++;
				end
				if (out_ch.last_output !== head.last) begin
					$error("last_output: expected %0b, got %0b", head.last, out_ch.last_output);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.act_elem = '0;
		in_ch.wt_elem = '0;
		in_ch.act_scale = '0;
		in_ch.wt_scale = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		burst_left = 0;
		rx_mode = RX_OPEN;
		rx_phase_left = 0;
		outputs_predicted = 0;
		mismatch_count = 0;
		reset_predictor();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_limits();
		test_partial_reconfig();
		test_largest_terms();
		test_longest_row();
		test_random_mix();
		test_index_wrap(2, 2);
		test_index_wrap(1, 3);

		settle_block();
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/gsm_pkg.sv
design/gsm_if.sv
design/gsm_fifo.sv
design/gsm_front.sv
design/gsm_back.sv
design/group_scaled_int8_matmul_top.sv
sim/group_scaled_int8_matmul_top_test.sv
